// ----- rtl/core/ltsm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Loop timing statistics monitor package
// Shared constants, payload types, controller states, command and status structs.
// ----------------------------------------------------------------------------
package ltsm_pkg;

  localparam int HIST_BUCKETS_DEF = 32;
  localparam logic [31:0] PERIOD_RESET = 32'd1000;
  localparam int SLOT_W = 5;
  localparam int MAX_WORDS = 32;

  // register byte addresses
  localparam logic [1:0] REG_PERIOD = 2'd0;

  // scalar slot codes
  localparam logic [4:0] SLOT_FIRST_TICK  = 5'd0;
  localparam logic [4:0] SLOT_LAST_TICK   = 5'd1;
  localparam logic [4:0] SLOT_WORST_TICK  = 5'd2;
  localparam logic [4:0] SLOT_COUNT       = 5'd3;
  localparam logic [4:0] SLOT_MAX_LATE    = 5'd4;
  localparam logic [4:0] SLOT_MAX_EXEC    = 5'd5;
  localparam logic [4:0] SLOT_MIN_SLACK   = 5'd6;
  localparam logic [4:0] SLOT_SKIPPED     = 5'd7;
  localparam logic [4:0] SLOT_MISSED      = 5'd8;
  localparam logic [4:0] SLOT_LONGEST_RUN = 5'd9;
  localparam logic [4:0] SLOT_FAILED      = 5'd10;

  typedef struct packed {
    logic [47:0]        tick_number;
    logic signed [31:0] wake_lateness_ns;
    logic [31:0]        execution_ns;
    logic signed [31:0] deadline_slack_ns;
    logic [15:0]        skipped_count;
    logic               sink_ready;
  } sample_t;

  typedef struct packed {
    logic [4:0]         slot;
    logic signed [63:0] scalar_value;
    logic [31:0]        wake_bucket_count;
    logic [31:0]        exec_bucket_count;
    logic               last_word;
  } word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_WRITE,
    ST_PUB_READ,
    ST_PUB_EMIT,
    ST_CLEAR
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture item, start bucket read
    logic update;     // scalar update and histogram write
    logic pub_read;   // read histogram at walk index
    logic pub_load;   // load output register
    logic walk_inc;
    logic walk_clr;
    logic clear;      // clear one histogram row at walk index
    logic clear_sum;  // clear scalars
    logic fail;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic publish;    // attempt due and sink ready
    logic attempt;
    logic walk_last;
    logic clear_last;
  } stat_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

endpackage

// ----- rtl/core/ltsm_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Valid/ready channel
// Carries one payload item with a source and a sink modport.
// ----------------------------------------------------------------------------
interface ltsm_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/ltsm_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Monitor controller
// Sequences sample update, histogram write, publication walk and clearing.
// ----------------------------------------------------------------------------
module ltsm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            out_free,
  input  ltsm_pkg::stat_t stat,
  output ltsm_pkg::cmd_t  cmd
);

  ltsm_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ltsm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ltsm_pkg::ST_IDLE: begin
        if (in_valid) state_next = ltsm_pkg::ST_UPDATE;
      end
      ltsm_pkg::ST_UPDATE: state_next = ltsm_pkg::ST_WRITE;
      ltsm_pkg::ST_WRITE: begin
        if (stat.publish) state_next = ltsm_pkg::ST_PUB_READ;
        else state_next = ltsm_pkg::ST_IDLE;
      end
      ltsm_pkg::ST_PUB_READ: state_next = ltsm_pkg::ST_PUB_EMIT;
      ltsm_pkg::ST_PUB_EMIT: begin
        if (out_free) begin
          if (stat.walk_last) state_next = ltsm_pkg::ST_CLEAR;
          else state_next = ltsm_pkg::ST_PUB_READ;
        end
      end
      ltsm_pkg::ST_CLEAR: begin
        if (stat.clear_last) state_next = ltsm_pkg::ST_IDLE;
      end
      default: state_next = ltsm_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ltsm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        cmd.walk_clr = 1'b1;
      end
      ltsm_pkg::ST_UPDATE: cmd.update = 1'b1;
      ltsm_pkg::ST_WRITE: begin
        cmd.fail = stat.attempt & ~stat.publish;
        cmd.walk_clr = 1'b1;
      end
      ltsm_pkg::ST_PUB_READ: cmd.pub_read = 1'b1;
      ltsm_pkg::ST_PUB_EMIT: begin
        cmd.pub_load = out_free;
        cmd.walk_inc = out_free & ~stat.walk_last;
        cmd.walk_clr = out_free & stat.walk_last;
      end
      ltsm_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
        cmd.walk_inc = 1'b1;
        cmd.clear_sum = stat.clear_last;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ----- rtl/core/ltsm_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Monitor datapath
// Summary registers, two histogram memories and the snapshot word builder.
// ----------------------------------------------------------------------------
module ltsm_dp #(
  parameter int HIST_BUCKETS = ltsm_pkg::HIST_BUCKETS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  ltsm_pkg::sample_t   sample,
  input  logic [31:0]         period,
  input  ltsm_pkg::cmd_t      cmd,
  output ltsm_pkg::stat_t     stat,
  output ltsm_pkg::word_t     word
);

  localparam int BW = $clog2(HIST_BUCKETS);
  localparam int WORDS = (HIST_BUCKETS > ltsm_pkg::MAX_WORDS) ? ltsm_pkg::MAX_WORDS
                                                             : HIST_BUCKETS;
  localparam logic [BW-1:0] TOP = BW'(HIST_BUCKETS - 1);
  localparam logic [BW-1:0] WLAST = BW'(WORDS - 1);

  ltsm_pkg::sample_t s;
  logic [31:0] sample_total, skipped_total, missed_total, longest_miss_run;
  logic [31:0] current_miss_run, failed_publish_total, samples_since_attempt;
  logic [31:0] max_execution;
  logic [47:0] first_tick, last_tick, worst_tick;
  logic signed [31:0] max_lateness, min_slack;
  logic [31:0] late_hist [HIST_BUCKETS];
  logic [31:0] exec_hist [HIST_BUCKETS];
  logic [31:0] late_rd, exec_rd;
  logic [BW-1:0] late_idx, exec_idx, lb, eb, walk;
  logic attempt;

  // bit length capped at the top bucket
  function automatic logic [BW-1:0] bucket_of(input logic [31:0] v);
    logic [5:0] len;
    len = 6'd0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) len = 6'(i + 1);
    end
    if ({26'd0, len} > 32'(HIST_BUCKETS - 1)) return TOP;
    return BW'(len);
  endfunction

  assign lb = bucket_of(sample.wake_lateness_ns[31] ? 32'd0 : sample.wake_lateness_ns);
  assign eb = bucket_of(sample.execution_ns);

  // item capture and histogram read
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s <= sample;
      late_idx <= lb;
      exec_idx <= eb;
      late_rd <= late_hist[lb];
      exec_rd <= exec_hist[eb];
    end else if (cmd.pub_read) begin
      late_rd <= late_hist[walk];
      exec_rd <= exec_hist[walk];
    end
  end

  // histogram writes
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      late_hist[walk] <= '0;
      exec_hist[walk] <= '0;
    end else if (cmd.update) begin
      late_hist[late_idx] <= ltsm_pkg::sat_inc(late_rd);
      exec_hist[exec_idx] <= ltsm_pkg::sat_inc(exec_rd);
    end
  end

  // walk index
  always_ff @(posedge clk) begin
    if (rst || cmd.walk_clr) walk <= '0;
    else if (cmd.walk_inc) walk <= walk + BW'(1);
  end

  assign stat.walk_last = (walk == WLAST);
  assign stat.clear_last = (walk == TOP);

  // attempt decision after the update
  assign attempt = (samples_since_attempt == '0);
  assign stat.attempt = attempt;
  assign stat.publish = attempt & s.sink_ready;

  // summary update
  always_ff @(posedge clk) begin
    logic [31:0] run, since;
    logic [32:0] sk;
    logic first;
    if (rst) begin
      sample_total <= '0; first_tick <= '0; last_tick <= '0; worst_tick <= '0;
      max_lateness <= '0; max_execution <= '0; min_slack <= '0;
      skipped_total <= '0; missed_total <= '0; longest_miss_run <= '0;
      current_miss_run <= '0; failed_publish_total <= '0;
      samples_since_attempt <= '0;
    end else if (cmd.update) begin
      first = (sample_total == '0);
      if (first) first_tick <= s.tick_number;
      last_tick <= s.tick_number;
      sample_total <= ltsm_pkg::sat_inc(sample_total);
      if (s.wake_lateness_ns > max_lateness) max_lateness <= s.wake_lateness_ns;
      if (s.execution_ns > max_execution) max_execution <= s.execution_ns;
      if (first || s.deadline_slack_ns < min_slack) begin
        min_slack <= s.deadline_slack_ns;
        worst_tick <= s.tick_number;
      end
      sk = {1'b0, skipped_total} + {17'd0, s.skipped_count};
      skipped_total <= sk[32] ? '1 : sk[31:0];
      if (s.deadline_slack_ns[31]) begin
        missed_total <= ltsm_pkg::sat_inc(missed_total);
        run = ltsm_pkg::sat_inc(current_miss_run);
        current_miss_run <= run;
        if (run > longest_miss_run) longest_miss_run <= run;
      end else begin
        current_miss_run <= '0;
      end
      since = ltsm_pkg::sat_inc(samples_since_attempt);
      samples_since_attempt <= (since < period) ? since : '0;
    end else if (cmd.fail) begin
      failed_publish_total <= ltsm_pkg::sat_inc(failed_publish_total);
    end else if (cmd.clear_sum) begin
      sample_total <= '0; first_tick <= '0; last_tick <= '0; worst_tick <= '0;
      max_lateness <= '0; max_execution <= '0; min_slack <= '0;
      skipped_total <= '0; missed_total <= '0; longest_miss_run <= '0;
      failed_publish_total <= '0; samples_since_attempt <= '0;
    end
  end

  // snapshot word
  always_ff @(posedge clk) begin
    logic [4:0] k;
    logic signed [63:0] sv;
    if (cmd.pub_load) begin
      k = 5'(walk);
      case (k)
        ltsm_pkg::SLOT_FIRST_TICK:  sv = {16'd0, first_tick};
        ltsm_pkg::SLOT_LAST_TICK:   sv = {16'd0, last_tick};
        ltsm_pkg::SLOT_WORST_TICK:  sv = {16'd0, worst_tick};
        ltsm_pkg::SLOT_COUNT:       sv = {32'd0, sample_total};
        ltsm_pkg::SLOT_MAX_LATE:    sv = 64'(max_lateness);
        ltsm_pkg::SLOT_MAX_EXEC:    sv = {32'd0, max_execution};
        ltsm_pkg::SLOT_MIN_SLACK:   sv = 64'(min_slack);
        ltsm_pkg::SLOT_SKIPPED:     sv = {32'd0, skipped_total};
        ltsm_pkg::SLOT_MISSED:      sv = {32'd0, missed_total};
        ltsm_pkg::SLOT_LONGEST_RUN: sv = {32'd0, longest_miss_run};
        ltsm_pkg::SLOT_FAILED:      sv = {32'd0, failed_publish_total};
        default:                    sv = '0;
      endcase
      word.slot <= k;
      word.scalar_value <= sv;
      word.wake_bucket_count <= late_rd;
      word.exec_bucket_count <= exec_rd;
      word.last_word <= (walk == WLAST);
    end
  end

endmodule

// ----- rtl/core/loop_timing_statistics_monitor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Loop timing statistics monitor
// Keeps servo timing statistics and histograms and publishes snapshots.
// ----------------------------------------------------------------------------
// channel   dir  payload
// s_in      in   tick, lateness, execution, slack, skipped, sink_ready
// m_out     out  slot, scalar, two bucket counts, last_word
// apb       in   publication_period at address 0
//
// an item passes through capture, histogram read-modify-write and decision
// a publishing item then adds a memory read and an output load per word
// plus a clearing sweep over every bucket; stalls on m_out hold it
// reset is synchronous; histograms are cleared only by a sweep: after each
// publication, and once after reset before the first item
module loop_timing_statistics_monitor #(
  parameter int HIST_BUCKETS = ltsm_pkg::HIST_BUCKETS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  ltsm_if.sink        s_in,
  ltsm_if.source      m_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ltsm_pkg::cmd_t  cmd;
  ltsm_pkg::stat_t stat;
  ltsm_pkg::word_t word;
  logic [31:0] period, period_eff;
  logic out_valid, out_free, idle_ready, swept;

  // configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) period <= ltsm_pkg::PERIOD_RESET;
    else if (psel && penable && pwrite && paddr == ltsm_pkg::REG_PERIOD) period <= pwdata;
  end
  assign prdata = (paddr == ltsm_pkg::REG_PERIOD) ? period : '0;
  assign period_eff = (period == '0) ? 32'd1 : period;

  // output register
  assign out_free = ~out_valid | m_out.ready;
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.pub_load) out_valid <= 1'b1;
    else if (m_out.ready) out_valid <= 1'b0;
  end
  assign m_out.valid = out_valid;
  assign m_out.data = word;

  // histogram memories come up undefined: sweep them once after reset
  always_ff @(posedge clk) begin
    if (rst) swept <= 1'b0;
    else if (stat.clear_last && cmd.clear) swept <= 1'b1;
  end

  logic ctrl_valid;
  assign ctrl_valid = s_in.valid & swept;
  assign s_in.ready = idle_ready & swept;

  ltsm_pkg::cmd_t ccmd;
  ltsm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(ctrl_valid), .in_ready(idle_ready),
    .out_free(out_free), .stat(stat), .cmd(ccmd)
  );

  // before the first sweep, drive a clearing pass
  always_comb begin
    cmd = ccmd;
    if (!swept) begin
      cmd = '0;
      cmd.clear = 1'b1;
      cmd.walk_inc = 1'b1;
    end
  end

  ltsm_dp #(.HIST_BUCKETS(HIST_BUCKETS)) u_dp (
    .clk(clk), .rst(rst), .sample(s_in.data), .period(period_eff),
    .cmd(cmd), .stat(stat), .word(word)
  );

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Loop timing statistics monitor testbench
// Feeds timing samples through the input channel under random gaps and
// stalls, changes the publication period between phases over the register
// port, and compares every snapshot word with a cycle-free predictor of the
// statistics and histograms kept alongside.
// ----------------------------------------------------------------------------
module tb;

  localparam int WORDS = 32;
  localparam int SETTLE = 80;

  typedef struct {
    logic [31:0]       period;
    ltsm_pkg::sample_t smp;
    int                n_words;
  } row_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ltsm_if #(.T(ltsm_pkg::sample_t)) in_ch ();
  ltsm_if #(.T(ltsm_pkg::word_t))   out_ch ();

  loop_timing_statistics_monitor i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_in    (in_ch),
    .m_out   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predicted statistics
  logic [31:0]        period_q;
  logic [31:0]        n_samples;
  logic [47:0]        tick_first;
  logic [47:0]        tick_last;
  logic [47:0]        tick_worst;
  logic signed [31:0] late_max;
  logic [31:0]        exec_max;
  logic signed [31:0] slack_min;
  logic [31:0]        skip_sum;
  logic [31:0]        miss_sum;
  logic [31:0]        run_longest;
  logic [31:0]        run_now;
  logic [31:0]        refused_sum;
  logic [31:0]        since_try;
  logic [31:0]        late_hist [WORDS];
  logic [31:0]        exec_hist [WORDS];

  ltsm_pkg::word_t snapshot_q [$];
  int    n_fail;
  bit    calm;
  int    stall_left;

  row_t directed [] = '{
    // period one: every sample tries to publish
    '{32'd1, '{48'd5, 32'sd0, 32'd0, 32'sd100, 16'd0, 1'b1}, WORDS},
    '{32'd1, '{48'hFFFF_FFFF_FFFF, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 32'sh7FFF_FFFF,
               16'hFFFF, 1'b1}, WORDS},
    '{32'd1, '{48'd0, 32'sh8000_0000, 32'd1, 32'sh8000_0000, 16'd1, 1'b0}, 0},
    '{32'd1, '{48'd7, -32'sd1, 32'd2, -32'sd1, 16'd0, 1'b0}, 0},
    '{32'd1, '{48'd8, 32'sd1, 32'd3, -32'sd5, 16'd2, 1'b1}, WORDS},
    '{32'd1, '{48'd9, 32'sd2, 32'd4, -32'sd6, 16'd3, 1'b1}, WORDS},
    // period zero acts as one
    '{32'd0, '{48'd10, 32'sd3, 32'd5, 32'sd0, 16'd0, 1'b1}, WORDS},
    '{32'd0, '{48'd11, 32'sh4000_0000, 32'h8000_0000, -32'sd7, 16'd0, 1'b0}, 0},
    // equal slack keeps the worst tick
    '{32'd4, '{48'd20, 32'sd5, 32'd6, 32'sd10, 16'd4, 1'b1}, 0},
    '{32'd4, '{48'd21, 32'sd6, 32'd7, 32'sd10, 16'd5, 1'b1}, 0},
    '{32'd4, '{48'd22, 32'sd7, 32'd8, 32'sd3, 16'd6, 1'b1}, 0},
    '{32'd4, '{48'd23, 32'sd8, 32'd9, 32'sd3, 16'd7, 1'b1}, WORDS},
    '{32'd4, '{48'd30, -32'sd9, 32'h0001_0000, -32'sd1, 16'd0, 1'b1}, 0},
    '{32'd4, '{48'd31, 32'sd255, 32'd256, -32'sd2, 16'd0, 1'b1}, 0},
    '{32'd4, '{48'd32, 32'sd256, 32'd255, 32'sd1, 16'd0, 1'b1}, 0},
    '{32'd4, '{48'd33, 32'sd0, 32'd0, -32'sd3, 16'd0, 1'b0}, 0},
    '{32'd4, '{48'd34, 32'sd1, 32'd1, -32'sd4, 16'd0, 1'b1}, 0},
    '{32'd4, '{48'd35, 32'sd1, 32'd1, 32'sd4, 16'd0, 1'b1}, 0},
    '{32'd4, '{48'd36, 32'sd1, 32'd1, 32'sd5, 16'd0, 1'b1}, 0},
    '{32'd4, '{48'd37, 32'sd1, 32'd1, 32'sd6, 16'd0, 1'b1}, WORDS}
  };

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int bit_len(logic [31:0] v);
    int n;
    n = 0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) n = i + 1;
    end
    return (n > WORDS - 1) ? WORDS - 1 : n;
  endfunction

  function automatic logic [31:0] plus_one(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic void clear_stats();
    n_samples   = '0;
    tick_first  = '0;
    tick_last   = '0;
    tick_worst  = '0;
    late_max    = '0;
    exec_max    = '0;
    slack_min   = '0;
    skip_sum    = '0;
    miss_sum    = '0;
    run_longest = '0;
    refused_sum = '0;
    since_try   = '0;
    for (int i = 0; i < WORDS; i++) begin
      late_hist[i] = '0;
      exec_hist[i] = '0;
    end
  endfunction

  // fold one sample into the statistics, queue the snapshot it publishes
  function automatic int absorb_sample(ltsm_pkg::sample_t s);
    logic [32:0]     sum;
    ltsm_pkg::word_t w;
    int              b;
    if (n_samples == 0) begin
      tick_first = s.tick_number;
      slack_min  = s.deadline_slack_ns;
      tick_worst = s.tick_number;
    end
    tick_last = s.tick_number;
    n_samples = plus_one(n_samples);
    if (s.wake_lateness_ns > late_max) late_max = s.wake_lateness_ns;
    if (s.execution_ns > exec_max) exec_max = s.execution_ns;
    if (s.deadline_slack_ns < slack_min) begin
      slack_min  = s.deadline_slack_ns;
      tick_worst = s.tick_number;
    end
    sum = {1'b0, skip_sum} + {17'd0, s.skipped_count};
    skip_sum = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    if (s.deadline_slack_ns < 0) begin
      miss_sum = plus_one(miss_sum);
      run_now  = plus_one(run_now);
      if (run_now > run_longest) run_longest = run_now;
    end else begin
      run_now = '0;
    end
    b = bit_len(s.wake_lateness_ns > 0 ? s.wake_lateness_ns : 32'd0);
    late_hist[b] = plus_one(late_hist[b]);
    b = bit_len(s.execution_ns);
    exec_hist[b] = plus_one(exec_hist[b]);
    since_try = plus_one(since_try);
    if (since_try < period_q) return 0;
    since_try = '0;
    if (!s.sink_ready) begin
      refused_sum = plus_one(refused_sum);
      return 0;
    end
    for (int k = 0; k < WORDS; k++) begin
      w.slot = k[4:0];
      case (k[4:0])
        ltsm_pkg::SLOT_FIRST_TICK:  w.scalar_value = {16'd0, tick_first};
        ltsm_pkg::SLOT_LAST_TICK:   w.scalar_value = {16'd0, tick_last};
        ltsm_pkg::SLOT_WORST_TICK:  w.scalar_value = {16'd0, tick_worst};
        ltsm_pkg::SLOT_COUNT:       w.scalar_value = {32'd0, n_samples};
        ltsm_pkg::SLOT_MAX_LATE:    w.scalar_value = 64'(late_max);
        ltsm_pkg::SLOT_MAX_EXEC:    w.scalar_value = {32'd0, exec_max};
        ltsm_pkg::SLOT_MIN_SLACK:   w.scalar_value = 64'(slack_min);
        ltsm_pkg::SLOT_SKIPPED:     w.scalar_value = {32'd0, skip_sum};
        ltsm_pkg::SLOT_MISSED:      w.scalar_value = {32'd0, miss_sum};
        ltsm_pkg::SLOT_LONGEST_RUN: w.scalar_value = {32'd0, run_longest};
        ltsm_pkg::SLOT_FAILED:      w.scalar_value = {32'd0, refused_sum};
        default:                    w.scalar_value = '0;
      endcase
      w.wake_bucket_count = late_hist[k];
      w.exec_bucket_count = exec_hist[k];
      w.last_word = (k == WORDS - 1);
      snapshot_q.push_back(w);
    end
    clear_stats();
    return WORDS;
  endfunction

  // output side: random stalls per word
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // snapshot word check
  always @(posedge clk) begin
    ltsm_pkg::word_t e;
    ltsm_pkg::word_t g;
    if (!rst && out_ch.valid && out_ch.ready) begin
      g = out_ch.data;
      stall_left <= calm ? 0 : $urandom_range(0, 14);
      if (snapshot_q.size() == 0) begin
        $error("unexpected word: slot %0d", g.slot);
        n_fail++;
      end else begin
        e = snapshot_q.pop_front();
        if (g.slot !== e.slot) begin
          $error("slot: expected %0d, got %0d", e.slot, g.slot);
          n_fail++;
        end
        if (g.scalar_value !== e.scalar_value) begin
          $error("scalar_value slot %0d: expected %0d, got %0d", e.slot,
                 e.scalar_value, g.scalar_value);
          n_fail++;
        end
        if (g.wake_bucket_count !== e.wake_bucket_count) begin
          $error("wake_bucket_count slot %0d: expected %0d, got %0d", e.slot,
                 e.wake_bucket_count, g.wake_bucket_count);
          n_fail++;
        end
        if (g.exec_bucket_count !== e.exec_bucket_count) begin
          $error("exec_bucket_count slot %0d: expected %0d, got %0d", e.slot,
                 e.exec_bucket_count, g.exec_bucket_count);
          n_fail++;
        end
        if (g.last_word !== e.last_word) begin
          $error("last_word slot %0d: expected %0d, got %0d", e.slot,
                 e.last_word, g.last_word);
          n_fail++;
        end
      end
    end
  end

  // drop the input, wait until all words are out and the clearing sweep is over
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (snapshot_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // register write followed by a read back
  task automatic set_period(logic [31:0] v);
    drain();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ltsm_pkg::REG_PERIOD;
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== v) begin
      $error("publication_period: expected %0d, got %0d", v, prdata);
      n_fail++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    period_q = v;
  endtask

  // one sample through the input handshake; called at a falling edge
  task automatic send(ltsm_pkg::sample_t s, output int n);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n = absorb_sample(s);
    @(negedge clk);
  endtask

  function automatic ltsm_pkg::sample_t random_sample();
    ltsm_pkg::sample_t s;
    s.tick_number = 48'({$urandom, $urandom});
    case ($urandom_range(0, 3))
      0: s.wake_lateness_ns = $urandom;
      1: s.wake_lateness_ns = 32'(-$signed({1'b0, $urandom_range(0, 5000)}));
      default: s.wake_lateness_ns = $urandom >> $urandom_range(0, 31);
    endcase
    s.execution_ns = ($urandom_range(0, 7) == 0) ? $urandom
                                                 : $urandom >> $urandom_range(0, 31);
    case ($urandom_range(0, 4))
      0: s.deadline_slack_ns = $urandom;
      1, 2: s.deadline_slack_ns = 32'(-$signed({1'b0, $urandom_range(0, 3000)}));
      default: s.deadline_slack_ns = $urandom_range(0, 3000);
    endcase
    s.skipped_count = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'd0;
    s.sink_ready = ($urandom_range(0, 4) != 0);
    return s;
  endfunction

  task automatic random_phase(logic [31:0] per, int count, bit quiet);
    int n;
    set_period(per);
    calm = quiet;
    for (int i = 0; i < count; i++) send(random_sample(), n);
    calm = 1'b0;
  endtask

  // stimulus
  initial begin
    int n;
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    stall_left   = 0;
    n_fail       = 0;
    calm         = 1'b0;
    period_q     = ltsm_pkg::PERIOD_RESET;
    run_now      = '0;
    clear_stats();
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed rows
    foreach (directed[i]) begin
      if (directed[i].period != period_q) set_period(directed[i].period);
      send(directed[i].smp, n);
      if (n != directed[i].n_words) begin
        $error("words for row %0d: expected %0d, got %0d", i,
               directed[i].n_words, n);
        n_fail++;
      end
    end

    // random phases, the largest period publishes nothing until lowered
    random_phase(32'd0, 6, 1'b0);
    random_phase(32'd5, 110, 1'b0);
    random_phase(32'hFFFF_FFFF, 40, 1'b1);
    random_phase(32'd2, 90, 1'b0);
    random_phase(32'd1, 30, 1'b1);
    random_phase(32'd17, 104, 1'b0);

    drain();
    if (n_fail == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule

// ----- loop_timing_statistics_monitor.f -----
rtl/core/ltsm_pkg.sv
rtl/core/ltsm_if.sv
rtl/core/ltsm_ctrl.sv
rtl/core/ltsm_dp.sv
rtl/core/loop_timing_statistics_monitor.sv
test/tb.sv
